// ===== hdl/rau_pkg.sv =====
// Shared types and constants for the rational arithmetic unit.
package rau_pkg;

    localparam int DATA_WIDTH_DEF = 64;

    typedef enum logic [1:0] {
        FUNC_ADD = 2'd0,
        FUNC_SUB = 2'd1,
        FUNC_MUL = 2'd2,
        FUNC_DIV = 2'd3
    } func_t;

    // datapath commands
    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,      // capture operands
        OP_GCD_START, // divider: n rem m
        OP_GCD_STEP,  // m <= rem, n <= m
        OP_L1_START,  // divider: xd / g
        OP_MUL_L,     // l <= q * yd
        OP_A_START,   // divider: l / xd
        OP_MUL_A,     // a <= q * xn
        OP_B_START,   // divider: l / yd
        OP_MUL_B,     // b <= q * yn, form result
        OP_MUL_DIRECT,
        OP_ZERO_ERR
    } op_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_LOAD,
        S_CHECK,
        S_GCD_DIV,
        S_GCD_WAIT,
        S_GCD_STEP,
        S_L_DIV,
        S_L_WAIT,
        S_A_DIV,
        S_A_WAIT,
        S_B_DIV,
        S_B_WAIT,
        S_MUL,
        S_ZERO,
        S_OUT
    } state_t;

    typedef struct packed {
        op_t  op;
        logic mul_go;
    } rau_cmd_t;

    typedef struct packed {
        logic addsub;
        logic den_zero;
        logic m_zero;
        logic div_done;
        logic mul_done;
    } rau_status_t;

endpackage

// ===== hdl/rau_divider.sv =====
// Iterative signed divider, one quotient bit per cycle, truncating.
module rau_divider #(
    parameter int DATA_WIDTH = rau_pkg::DATA_WIDTH_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [DATA_WIDTH-1:0] dividend,
    input  logic [DATA_WIDTH-1:0] divisor,
    output logic                  done,
    output logic [DATA_WIDTH-1:0] quotient,
    output logic [DATA_WIDTH-1:0] remainder
);
    localparam int CW = $clog2(DATA_WIDTH + 1);

    logic [DATA_WIDTH-1:0] q_reg, q_next;
    logic [DATA_WIDTH-1:0] r_reg, r_next;
    logic [DATA_WIDTH-1:0] d_reg, d_next;
    logic [CW-1:0]         cnt_reg, cnt_next;
    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic                  qneg_reg, qneg_next;
    logic                  rneg_reg, rneg_next;
    logic [DATA_WIDTH:0]   trial;
    logic [DATA_WIDTH-1:0] rshift;

    always_comb
    begin
        q_next    = q_reg;
        r_next    = r_reg;
        d_next    = d_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        qneg_next = qneg_reg;
        rneg_next = rneg_reg;
        rshift    = {r_reg[DATA_WIDTH-2:0], q_reg[DATA_WIDTH-1]};
        trial     = {r_reg, q_reg[DATA_WIDTH-1]} - {1'b0, d_reg};
        if (start)
        begin
            q_next    = dividend[DATA_WIDTH-1] ? -dividend : dividend;
            d_next    = divisor[DATA_WIDTH-1] ? -divisor : divisor;
            r_next    = '0;
            cnt_next  = CW'(DATA_WIDTH);
            busy_next = 1'b1;
            qneg_next = dividend[DATA_WIDTH-1] ^ divisor[DATA_WIDTH-1];
            rneg_next = dividend[DATA_WIDTH-1];
        end
        else if (busy_reg)
        begin
            if (!trial[DATA_WIDTH])
            begin
                r_next = trial[DATA_WIDTH-1:0];
                q_next = {q_reg[DATA_WIDTH-2:0], 1'b1};
            end
            else
            begin
                r_next = rshift;
                q_next = {q_reg[DATA_WIDTH-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
                if (d_reg == '0)
                begin
                    q_next = '0;
                    r_next = '0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg    <= q_next;
        r_reg    <= r_next;
        d_reg    <= d_next;
        qneg_reg <= qneg_next;
        rneg_reg <= rneg_next;
    end

    assign done      = done_reg;
    assign quotient  = qneg_reg ? -q_reg : q_reg;
    assign remainder = rneg_reg ? -r_reg : r_reg;
endmodule

// ===== hdl/rau_multiplier.sv =====
// Wrapping multiplier built from 32x32 partial products, accumulated one after another.
module rau_multiplier #(
    parameter int DATA_WIDTH = rau_pkg::DATA_WIDTH_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [DATA_WIDTH-1:0] a,
    input  logic [DATA_WIDTH-1:0] b,
    output logic                  done,
    output logic [DATA_WIDTH-1:0] product
);
    localparam int HW = (DATA_WIDTH + 1) / 2;
    localparam int FW = 2 * HW;

    logic [FW-1:0]         a_reg, b_reg;
    logic [DATA_WIDTH-1:0] acc_reg, acc_next;
    logic [1:0]            ph_reg, ph_next;
    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [HW-1:0]         pa, pb;
    logic [FW-1:0]         pp;
    logic [FW-1:0]         pp_sh;

    always_comb
    begin
        pa = ph_reg[1] ? a_reg[FW-1:HW] : a_reg[HW-1:0];
        pb = ph_reg[0] ? b_reg[FW-1:HW] : b_reg[HW-1:0];
        pp = FW'(pa) * FW'(pb);
        case (ph_reg)
            2'd0:    pp_sh = pp;
            2'd3:    pp_sh = '0;
            default: pp_sh = pp << HW;
        endcase
        acc_next  = acc_reg;
        ph_next   = ph_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            acc_next  = '0;
            ph_next   = 2'd0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            acc_next = acc_reg + pp_sh[DATA_WIDTH-1:0];
            ph_next  = ph_reg + 2'd1;
            if (ph_reg == 2'd2)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            ph_reg   <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            ph_reg   <= ph_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        if (start)
        begin
            a_reg <= FW'(a);
            b_reg <= FW'(b);
        end
    end

    assign done    = done_reg;
    assign product = acc_reg;
endmodule

// ===== hdl/rau_datapath.sv =====
// Operand registers, divider, multiplier and result registers.
module rau_datapath #(
    parameter int DATA_WIDTH = rau_pkg::DATA_WIDTH_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  rau_pkg::rau_cmd_t    cmd,
    output rau_pkg::rau_status_t status,
    input  logic [1:0]           func,
    input  logic signed [63:0]   x_num,
    input  logic signed [63:0]   x_den,
    input  logic signed [63:0]   y_num,
    input  logic signed [63:0]   y_den,
    output logic signed [63:0]   result_num,
    output logic signed [63:0]   result_den,
    output logic                 zero_den_error
);
    localparam int W = DATA_WIDTH;

    logic [1:0]   func_reg;
    logic [W-1:0] xn_reg, xd_reg, yn_reg, yd_reg;
    logic [W-1:0] m_reg, n_reg, l_reg, a_reg;
    logic [W-1:0] rn_reg, rd_reg;
    logic         err_reg;
    logic         div_start, div_done, mul_done;
    logic [W-1:0] div_a, div_b, quo, rem;
    logic [W-1:0] mul_a, mul_b, prod;

    always_comb
    begin
        div_start = 1'b0;
        div_a     = n_reg;
        div_b     = m_reg;
        case (cmd.op)
            rau_pkg::OP_GCD_START: div_start = 1'b1;
            rau_pkg::OP_L1_START:
            begin
                div_start = 1'b1;
                div_a     = xd_reg;
                div_b     = n_reg;
            end
            rau_pkg::OP_A_START:
            begin
                div_start = 1'b1;
                div_a     = l_reg;
                div_b     = xd_reg;
            end
            rau_pkg::OP_B_START:
            begin
                div_start = 1'b1;
                div_a     = l_reg;
                div_b     = yd_reg;
            end
            default: ;
        endcase
    end

    always_comb
    begin
        mul_a = quo;
        mul_b = yd_reg;
        case (cmd.op)
            rau_pkg::OP_MUL_A: mul_b = xn_reg;
            rau_pkg::OP_MUL_B: mul_b = yn_reg;
            rau_pkg::OP_MUL_DIRECT:
            begin
                // numerator first; when it completes the denominator is launched
                if (mul_done)
                begin
                    mul_a = xd_reg;
                    mul_b = (func_reg == rau_pkg::FUNC_DIV) ? yn_reg : yd_reg;
                end
                else
                begin
                    mul_a = xn_reg;
                    mul_b = (func_reg == rau_pkg::FUNC_DIV) ? yd_reg : yn_reg;
                end
            end
            default: ;
        endcase
    end

    rau_divider #(.DATA_WIDTH(W)) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_a),
        .divisor   (div_b),
        .done      (div_done),
        .quotient  (quo),
        .remainder (rem)
    );

    rau_multiplier #(.DATA_WIDTH(W)) u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (cmd.mul_go),
        .a       (mul_a),
        .b       (mul_b),
        .done    (mul_done),
        .product (prod)
    );

    // direct multiply needs a second product for the denominator; it
    // runs after the numerator through the same unit and lands in rd
    always_ff @(posedge clk)
    begin
        case (cmd.op)
            rau_pkg::OP_LOAD:
            begin
                func_reg <= func;
                xn_reg   <= x_num[W-1:0];
                xd_reg   <= x_den[W-1:0];
                yn_reg   <= y_num[W-1:0];
                yd_reg   <= y_den[W-1:0];
                m_reg    <= x_den[W-1:0];
                n_reg    <= y_den[W-1:0];
                err_reg  <= 1'b0;
            end
            rau_pkg::OP_GCD_STEP:
            begin
                m_reg <= rem;
                n_reg <= m_reg;
            end
            rau_pkg::OP_MUL_L: if (mul_done) l_reg <= prod;
            rau_pkg::OP_MUL_A: if (mul_done) a_reg <= prod;
            rau_pkg::OP_MUL_B:
            begin
                if (mul_done)
                begin
                    rn_reg <= (func_reg == rau_pkg::FUNC_ADD) ? a_reg + prod
                                                             : a_reg - prod;
                    rd_reg <= l_reg;
                end
            end
            rau_pkg::OP_MUL_DIRECT: if (mul_done) rn_reg <= prod;
            rau_pkg::OP_ZERO_ERR:
            begin
                rn_reg  <= '0;
                rd_reg  <= '0;
                err_reg <= 1'b1;
            end
            default: ;
        endcase
        if (cmd.op == rau_pkg::OP_NONE && mul_done)
            rd_reg <= prod;
    end

    always_comb
    begin
        status.addsub   = ~func_reg[1];
        status.den_zero = (xd_reg == '0) || (yd_reg == '0);
        status.m_zero   = (m_reg == '0);
        status.div_done = div_done;
        status.mul_done = mul_done;
    end

    assign result_num     = 64'(signed'(rn_reg));
    assign result_den     = 64'(signed'(rd_reg));
    assign zero_den_error = err_reg;
endmodule

// ===== hdl/rau_controller.sv =====
// Sequencing state machine for the rational arithmetic unit.
module rau_controller (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    output logic                 out_valid,
    input  logic                 out_ready,
    input  rau_pkg::rau_status_t status,
    output rau_pkg::rau_cmd_t    cmd,
    output logic                 mul_den
);
    rau_pkg::state_t state_reg, state_next;
    logic            den_reg, den_next; // direct multiply: second product pending

    always_comb
    begin
        state_next = state_reg;
        den_next   = den_reg;
        unique case (state_reg)
            rau_pkg::S_IDLE: if (in_valid) state_next = rau_pkg::S_LOAD;
            rau_pkg::S_LOAD: state_next = rau_pkg::S_CHECK;
            rau_pkg::S_CHECK:
            begin
                if (!status.addsub)
                begin
                    state_next = rau_pkg::S_MUL;
                    den_next   = 1'b0;
                end
                else if (status.den_zero)
                    state_next = rau_pkg::S_ZERO;
                else
                    state_next = rau_pkg::S_GCD_DIV;
            end
            rau_pkg::S_GCD_DIV: state_next = status.m_zero ? rau_pkg::S_L_DIV
                                                           : rau_pkg::S_GCD_WAIT;
            rau_pkg::S_GCD_WAIT: if (status.div_done) state_next = rau_pkg::S_GCD_STEP;
            rau_pkg::S_GCD_STEP: state_next = rau_pkg::S_GCD_DIV;
            rau_pkg::S_L_DIV: state_next = rau_pkg::S_L_WAIT;
            rau_pkg::S_L_WAIT: if (status.mul_done) state_next = rau_pkg::S_A_DIV;
            rau_pkg::S_A_DIV: state_next = rau_pkg::S_A_WAIT;
            rau_pkg::S_A_WAIT: if (status.mul_done) state_next = rau_pkg::S_B_DIV;
            rau_pkg::S_B_DIV: state_next = rau_pkg::S_B_WAIT;
            rau_pkg::S_B_WAIT: if (status.mul_done) state_next = rau_pkg::S_OUT;
            rau_pkg::S_MUL:
            begin
                if (status.mul_done)
                begin
                    if (den_reg)
                        state_next = rau_pkg::S_OUT;
                    den_next = 1'b1;
                end
            end
            rau_pkg::S_ZERO: state_next = rau_pkg::S_OUT;
            rau_pkg::S_OUT: if (out_ready) state_next = rau_pkg::S_IDLE;
            default: state_next = rau_pkg::S_IDLE;
        endcase
    end

    // divider finishing and multiplier start are chained inside the
    // wait states: a wait state first waits for the quotient, then the product
    logic ph_reg, ph_next; // 0: waiting divider, 1: waiting multiplier

    always_comb
    begin
        ph_next = ph_reg;
        if (state_reg == rau_pkg::S_L_WAIT || state_reg == rau_pkg::S_A_WAIT ||
            state_reg == rau_pkg::S_B_WAIT)
        begin
            if (!ph_reg && status.div_done)
                ph_next = 1'b1;
            else if (ph_reg && status.mul_done)
                ph_next = 1'b0;
        end
    end

    always_comb
    begin
        cmd.op     = rau_pkg::OP_NONE;
        cmd.mul_go = 1'b0;
        in_ready   = 1'b0;
        out_valid  = 1'b0;
        mul_den    = 1'b0;
        unique case (state_reg)
            rau_pkg::S_IDLE: in_ready = 1'b1;
            rau_pkg::S_LOAD: ;
            rau_pkg::S_CHECK: ;
            rau_pkg::S_GCD_DIV: cmd.op = status.m_zero ? rau_pkg::OP_L1_START
                                                       : rau_pkg::OP_GCD_START;
            rau_pkg::S_GCD_WAIT: ;
            rau_pkg::S_GCD_STEP: cmd.op = rau_pkg::OP_GCD_STEP;
            rau_pkg::S_L_DIV: ;
            rau_pkg::S_L_WAIT:
            begin
                cmd.op     = rau_pkg::OP_MUL_L;
                cmd.mul_go = !ph_reg && status.div_done;
            end
            rau_pkg::S_A_DIV: cmd.op = rau_pkg::OP_A_START;
            rau_pkg::S_A_WAIT:
            begin
                cmd.op     = rau_pkg::OP_MUL_A;
                cmd.mul_go = !ph_reg && status.div_done;
            end
            rau_pkg::S_B_DIV: cmd.op = rau_pkg::OP_B_START;
            rau_pkg::S_B_WAIT:
            begin
                cmd.op     = rau_pkg::OP_MUL_B;
                cmd.mul_go = !ph_reg && status.div_done;
            end
            rau_pkg::S_MUL:
            begin
                cmd.op  = den_reg ? rau_pkg::OP_NONE : rau_pkg::OP_MUL_DIRECT;
                mul_den = den_reg;
                cmd.mul_go = (state_reg != state_next) ? 1'b0 : 1'b0;
            end
            rau_pkg::S_ZERO: cmd.op = rau_pkg::OP_ZERO_ERR;
            rau_pkg::S_OUT: out_valid = 1'b1;
            default: ;
        endcase
        if (state_reg == rau_pkg::S_CHECK && !status.addsub)
            cmd.mul_go = 1'b1;
        if (state_reg == rau_pkg::S_MUL && !den_reg && status.mul_done)
            cmd.mul_go = 1'b1;
        if (state_reg == rau_pkg::S_CHECK && !status.addsub)
            cmd.op = rau_pkg::OP_MUL_DIRECT;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= rau_pkg::S_IDLE;
            den_reg   <= 1'b0;
            ph_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            den_reg   <= den_next;
            ph_reg    <= ph_next;
        end
    end
endmodule

// ===== hdl/rational_arithmetic_unit.sv =====
// Rational arithmetic unit: combines two fractions, result left unreduced.
// Add/sub runs Euclid remainder steps on the one-bit-per-cycle divider, then
// three divide/multiply pairs for lcm and scaling.
// One word in flight: the next word is accepted no earlier than the cycle after the result is delivered.
// rst_n clears the controller asynchronously; operand registers are not reset.
module rational_arithmetic_unit #(
    parameter int DATA_WIDTH = rau_pkg::DATA_WIDTH_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [1:0]         func,
    input  logic signed [63:0] x_num,
    input  logic signed [63:0] x_den,
    input  logic signed [63:0] y_num,
    input  logic signed [63:0] y_den,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [63:0] result_num,
    output logic signed [63:0] result_den,
    output logic               zero_den_error
);
    rau_pkg::rau_cmd_t    cmd;
    rau_pkg::rau_status_t status;
    rau_pkg::rau_cmd_t    dp_cmd;
    logic                 mul_den;

    rau_controller u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd),
        .mul_den   (mul_den)
    );

    // load happens on the accepting edge
    always_comb
    begin
        dp_cmd = cmd;
        if (in_valid && in_ready)
            dp_cmd.op = rau_pkg::OP_LOAD;
        if (mul_den)
            dp_cmd.op = rau_pkg::OP_NONE;
    end

    rau_datapath #(.DATA_WIDTH(DATA_WIDTH)) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (dp_cmd),
        .status         (status),
        .func           (func),
        .x_num          (x_num),
        .x_den          (x_den),
        .y_num          (y_num),
        .y_den          (y_den),
        .result_num     (result_num),
        .result_den     (result_den),
        .zero_den_error (zero_den_error)
    );
endmodule
